// ===== rtl/max_segment_cut_count_macros.svh =====
// ----------------------------------------------------------------------------
// max_segment_cut_count_macros
// Assertion macros used by the cut-count sequencer; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MAX_SEGMENT_CUT_COUNT_MACROS_SVH
`define MAX_SEGMENT_CUT_COUNT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msc assertion failed");

// next-cycle implication
`define MSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msc assertion failed");

`else

`define MSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msc_pkg;

    localparam int LEN_W   = 10;
    localparam int COUNT_W = 10;
    localparam int ENTRY_W = COUNT_W + 1;   // valid bit on top of the count

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch query word
        logic zero;      // write entry 0, seed result
        logic iss_a;     // read for len_a, write back previous entry
        logic iss_b;     // read for len_b, fold len_a data
        logic iss_c;     // read for len_c, fold len_b data
        logic fin;       // fold len_c data, write last entry, set result
        logic out_load;  // move result into output registers
    } ctrl_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic over;        // incoming total beyond table range
        logic total_zero;  // latched total is 0
        logic last;        // index has reached the total
    } dp_stat_t;

endpackage

// ===== rtl/max_segment_cut_count.sv =====
// ----------------------------------------------------------------------------
// max_segment_cut_count
// Greatest piece count for an exact cut of a length into three segment sizes.
// Sequence: load, seed entry 0, three reads per entry, final fold, hand-off;
//   a zero total skips the reads, a total beyond MAX_LENGTH goes to hand-off.
// Queries: one at a time; each table entry takes one read per segment length
//   through the single read port of the table RAM.
// Reset: asynchronous, active low; clears the sequencer and output valid.
//   The table RAM is not cleared; each query rewrites entries 0..total first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_segment_cut_count
    import msc_pkg::*;
#(
    parameter int MAX_LENGTH = 1023
) (
    input  logic               clk,
    input  logic               rst_n,
    // query word
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEN_W-1:0]   total_length,
    input  logic [LEN_W-1:0]   len_a,
    input  logic [LEN_W-1:0]   len_b,
    input  logic [LEN_W-1:0]   len_c,
    // result word
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] max_pieces,
    output logic               possible
);

    // Only entries up to the largest reachable total are stored; the input
    // field is 10 bits, so a MAX_LENGTH above 1023 adds nothing.
    localparam int LAST_IDX  = (MAX_LENGTH < 1023) ? MAX_LENGTH : 1023;
    localparam int TBL_DEPTH = LAST_IDX + 1;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer: per entry i it issues reads at i-len_a, i-len_b, i-len_c on
    // consecutive cycles; the finished entry is written back in the cycle
    // that issues the first read of the next entry.
    msc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: table RAM (valid bit + count per length), fold of the three
    // reads into a running best, forwarding for a read of the entry being
    // written, and the output register that frees the sequencer.
    msc_datapath #(
        .MAX_LENGTH(MAX_LENGTH),
        .TBL_DEPTH (TBL_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .total_length(total_length),
        .len_a       (len_a),
        .len_b       (len_b),
        .len_c       (len_c),
        .max_pieces  (max_pieces),
        .possible    (possible),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== rtl/msc_ram.sv =====
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/msc_datapath.sv =====
// ----------------------------------------------------------------------------
// msc_datapath
// Query registers, table index, table RAM, fold logic and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_datapath
    import msc_pkg::*;
#(
    parameter int MAX_LENGTH = 1023,
    parameter int TBL_DEPTH  = 1024,
    parameter int ADDR_W     = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEN_W-1:0]   total_length,
    input  logic [LEN_W-1:0]   len_a,
    input  logic [LEN_W-1:0]   len_b,
    input  logic [LEN_W-1:0]   len_c,
    output logic [COUNT_W-1:0] max_pieces,
    output logic               possible,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat
);

    localparam logic [COUNT_W-1:0] CNT_MAX   = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_ZRO = {1'b1, {COUNT_W{1'b0}}};

    logic [LEN_W-1:0]   total_reg, la_reg, lb_reg, lc_reg;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic               use_reg, use_next;
    logic               acc_ok_reg, acc_ok_next;
    logic [COUNT_W-1:0] acc_best_reg, acc_best_next;
    logic               byp_reg, byp_next;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               res_ok_reg, res_ok_next;
    logic [COUNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic [COUNT_W-1:0] max_pieces_reg;
    logic               possible_reg;

    logic               we;
    logic [LEN_W-1:0]   waddr_full, raddr_full, seg;
    logic [ENTRY_W-1:0] wdata, ram_q, rd_entry;
    logic               issuing;
    logic               hit;
    logic [COUNT_W-1:0] cand;
    logic               mrg_ok;
    logic [COUNT_W-1:0] mrg_best;

    // fold one table read into the running best
    assign rd_entry = byp_reg ? byp_data_reg : ram_q;
    assign hit      = use_reg & rd_entry[ENTRY_W-1];
    assign cand     = (rd_entry[COUNT_W-1:0] == CNT_MAX) ? CNT_MAX
                                                          : rd_entry[COUNT_W-1:0] + 1'b1;

    always_comb
    begin
        mrg_ok   = acc_ok_reg | hit;
        mrg_best = acc_best_reg;
        if (hit && (!acc_ok_reg || cand > acc_best_reg))
        begin
            mrg_best = cand;
        end
    end

    assign issuing = cmd.iss_a | cmd.iss_b | cmd.iss_c;

    always_comb
    begin
        seg = la_reg;
        if (cmd.iss_b)
        begin
            seg = lb_reg;
        end
        else if (cmd.iss_c)
        begin
            seg = lc_reg;
        end
    end

    // table write and read ports
    always_comb
    begin
        we         = 1'b0;
        waddr_full = idx_reg;
        wdata      = {mrg_ok, mrg_best};
        if (cmd.zero)
        begin
            we         = 1'b1;
            waddr_full = '0;
            wdata      = ENTRY_ZRO;
        end
        else if (cmd.iss_a && idx_reg != LEN_W'(1))
        begin
            we         = 1'b1;
            waddr_full = idx_reg - 1'b1;
        end
        else if (cmd.fin)
        begin
            we = 1'b1;
        end
    end

    assign use_next   = issuing ? ((seg != '0) && (seg <= idx_reg)) : use_reg;
    assign raddr_full = use_next && issuing ? idx_reg - seg : '0;
    // entry written this cycle is forwarded to a read of it issued in this cycle
    assign byp_next   = we & issuing & (waddr_full == raddr_full);

    msc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr_full[ADDR_W-1:0]),
        .wdata(wdata),
        .raddr(raddr_full[ADDR_W-1:0]),
        .rdata(ram_q)
    );

    always_comb
    begin
        acc_ok_next   = acc_ok_reg;
        acc_best_next = acc_best_reg;
        if (cmd.iss_a)
        begin
            acc_ok_next   = 1'b0;
            acc_best_next = '0;
        end
        else if (cmd.iss_b || cmd.iss_c)
        begin
            acc_ok_next   = mrg_ok;
            acc_best_next = mrg_best;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.zero)
        begin
            idx_next = LEN_W'(1);
        end
        else if (cmd.iss_c && !stat.last)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_ok_next  = res_ok_reg;
        res_cnt_next = res_cnt_reg;
        if (cmd.load)
        begin
            res_ok_next  = 1'b0;
            res_cnt_next = '0;
        end
        else if (cmd.zero)
        begin
            res_ok_next  = 1'b1;
            res_cnt_next = '0;
        end
        else if (cmd.fin)
        begin
            res_ok_next  = mrg_ok;
            res_cnt_next = mrg_best;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            total_reg <= total_length;
            la_reg    <= len_a;
            lb_reg    <= len_b;
            lc_reg    <= len_c;
        end
        if (cmd.out_load)
        begin
            max_pieces_reg <= res_cnt_reg;
            possible_reg   <= res_ok_reg;
        end
        use_reg      <= use_next;
        acc_ok_reg   <= acc_ok_next;
        acc_best_reg <= acc_best_next;
        byp_data_reg <= wdata;
        res_ok_reg   <= res_ok_next;
        res_cnt_reg  <= res_cnt_next;
    end

    assign stat.over       = {7'd0, total_length} > 17'(MAX_LENGTH);
    assign stat.total_zero = (total_reg == '0);
    assign stat.last       = (idx_reg == total_reg);

    assign max_pieces = max_pieces_reg;
    assign possible   = possible_reg;

endmodule

// ===== rtl/msc_ctrl.sv =====
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: three table reads per entry, then result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_segment_cut_count_macros.svh"

module msc_ctrl
    import msc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ZERO = 3'd1;
    localparam logic [2:0] S_A    = 3'd2;
    localparam logic [2:0] S_B    = 3'd3;
    localparam logic [2:0] S_C    = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.over ? S_DONE : S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.zero   = 1'b1;
                state_next = stat.total_zero ? S_DONE : S_A;
            end
            S_A:
            begin
                cmd.iss_a  = 1'b1;
                state_next = S_B;
            end
            S_B:
            begin
                cmd.iss_b  = 1'b1;
                state_next = S_C;
            end
            S_C:
            begin
                cmd.iss_c  = 1'b1;
                state_next = stat.last ? S_FIN : S_A;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `MSC_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != S_IDLE)
    `MSC_ASSERT_NXT(a_entry_loops, clk, rst_n, state_reg == S_C && !stat.last, state_reg == S_A)
    `MSC_ASSERT_IMP(a_one_step, clk, rst_n, 1'b1, $onehot0({cmd.zero, cmd.iss_a, cmd.iss_b, cmd.iss_c, cmd.fin}))
    `MSC_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_segment_cut_count. A directed table covers the
// corner cases first. Random queries follow, most of them small, in four
// traffic phases with gaps on the query side and stalls on the result side.
// Each accepted query word is scored against its typed result or else an
// in-bench copy of the bottom-up cut table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import msc_pkg::*;

    // Settle window sized for the longest table fill.
    localparam int MAX_LEN        = 1023;
    localparam int SETTLE_CYCLES  = 3 * MAX_LEN + 3;
    // Worst case: every query at full length plus long stalls, several times over.
    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int NUM_ROWS       = 19;

    // One result word as the block returns it.
    typedef struct packed {
        logic [COUNT_W-1:0] pieces;
        logic               possible;
    } cut_result_t;

    // One row of the directed table. When 'typed' is set the expected result
    // is written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [LEN_W-1:0] c;
        logic             typed;
        cut_result_t      want;
    } cut_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [LEN_W-1:0]   total_length;
    logic [LEN_W-1:0]   len_a;
    logic [LEN_W-1:0]   len_b;
    logic [LEN_W-1:0]   len_c;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] max_pieces;
    logic               possible;

    // Predictor state: best count per length, valid bit on top.
    logic [ENTRY_W-1:0] cut_table [0:MAX_LEN];
    logic [LEN_W-1:0]   last_filled;

    cut_result_t        pending_results [$];
    cut_row_t           directed_rows [0:NUM_ROWS-1];

    // Typed expectation for the word now on the query port (directed rows).
    logic               row_typed;
    cut_result_t        row_want;

    int                 send_gap_pct;
    int                 recv_stall_pct;
    int                 fail_count;
    int                 cycle_count;

    max_segment_cut_count #(
        .MAX_LENGTH (MAX_LEN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .total_length (total_length),
        .len_a        (len_a),
        .len_b        (len_b),
        .len_c        (len_c),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .max_pieces   (max_pieces),
        .possible     (possible)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: fills lengths 0..total bottom up. Entry i is valid when some
    // allowed segment ends on a valid entry; the count is the best such
    // count plus one. Zero lengths and lengths beyond i are skipped.
    // ------------------------------------------------------------------------
    function automatic cut_result_t predict_cut(input logic [LEN_W-1:0] total,
                                                input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b,
                                                input logic [LEN_W-1:0] c);
        cut_result_t        res;
        logic [LEN_W-1:0]   segs [0:2];
        logic [ENTRY_W-1:0] prev;
        int                 best;
        int                 cand;
        bit                 ok;
        res  = '0;
        segs[0] = a;
        segs[1] = b;
        segs[2] = c;
        // unreachable at 10 bits, kept for parity with the block's range check
        if (int'(total) > MAX_LEN)
            return res;
        cut_table[0] = {1'b1, {COUNT_W{1'b0}}};
        for (int i = 1; i <= int'(total); i++)
        begin
            ok   = 1'b0;
            best = 0;
            for (int s = 0; s < 3; s++)
            begin
                if (segs[s] != '0 && int'(segs[s]) <= i)
                begin
                    prev = cut_table[i - int'(segs[s])];
                    if (prev[ENTRY_W-1])
                    begin
                        cand = int'(prev[COUNT_W-1:0]) + 1;
                        if (cand > (1 << COUNT_W) - 1)
                            cand = (1 << COUNT_W) - 1;  // saturate
                        if (!ok || cand > best)
                            best = cand;
                        ok = 1'b1;
                    end
                end
            end
            cut_table[i] = ok ? {1'b1, COUNT_W'(best)} : '0;
        end
        last_filled = total;
        if (cut_table[total][ENTRY_W-1])
        begin
            res.pieces   = cut_table[total][COUNT_W-1:0];
            res.possible = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Query driver. Called at a falling edge; returns at the falling edge
    // after the word is taken. in_valid is only dropped for a gap, so it
    // never gets a low and a high in the same step.
    // ------------------------------------------------------------------------
    task automatic send_query(input logic [LEN_W-1:0] t,
                              input logic [LEN_W-1:0] a,
                              input logic [LEN_W-1:0] b,
                              input logic [LEN_W-1:0] c,
                              input logic             typed,
                              input cut_result_t      want);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed    = typed;
        row_want     = want;
        in_valid     <= 1'b1;
        total_length <= t;
        len_a        <= a;
        len_b        <= b;
        len_c        <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the query side off until every result word is back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Random segment length for the common case: mostly short, sometimes unused.
    function automatic logic [LEN_W-1:0] short_len();
        if ($urandom_range(0, 5) == 0)
            return '0;
        return LEN_W'($urandom_range(1, 24));
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready is redrawn every falling edge from the stall rate.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Scoreboard. Sampled at the rising edge, before the block's own updates
    // land. A taken query word queues its expectation; a taken result word
    // is compared with the oldest one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : score_words
        cut_result_t predicted;
        cut_result_t oldest;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                // predictor runs on every word so its table tracks the block
                predicted = predict_cut(total_length, len_a, len_b, len_c);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected: max_pieces %0d possible %0d",
                           max_pieces, possible);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (max_pieces !== oldest.pieces)
                    begin
                        $error("max_pieces: expected %0d, actual %0d",
                               oldest.pieces, max_pieces);
                        fail_count++;
                    end
                    if (possible !== oldest.possible)
                    begin
                        $error("possible: expected %0d, actual %0d",
                               oldest.possible, possible);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL max_segment_cut_count");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : run_stimulus
        logic [LEN_W-1:0] t;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [LEN_W-1:0] c;
        int               pick;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        total_length   = '0;
        len_a          = '0;
        len_b          = '0;
        len_c          = '0;
        row_typed      = 1'b0;
        row_want       = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        cycle_count    = 0;
        last_filled    = '0;

        // total, a, b, c, typed, {pieces, possible}
        directed_rows = '{
            // zero total is always possible with 0 pieces
            '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, '{10'd0,    1'b1}},
            '{10'd0,    10'd1023, 10'd1023, 10'd1023, 1'b1, '{10'd0,    1'b1}},
            // all lengths unused
            '{10'd5,    10'd0,    10'd0,    10'd0,    1'b1, '{10'd0,    1'b0}},
            // every segment longer than the total
            '{10'd5,    10'd7,    10'd9,    10'd11,   1'b1, '{10'd0,    1'b0}},
            '{10'd1,    10'd1,    10'd0,    10'd0,    1'b1, '{10'd1,    1'b1}},
            // full length in unit pieces: largest count
            '{10'd1023, 10'd1,    10'd0,    10'd0,    1'b1, '{10'd1023, 1'b1}},
            '{10'd1023, 10'd1023, 10'd0,    10'd0,    1'b1, '{10'd1,    1'b1}},
            '{10'd1023, 10'd0,    10'd0,    10'd1023, 1'b1, '{10'd1,    1'b1}},
            '{10'd1023, 10'd1022, 10'd1021, 10'd2,    1'b0, '{10'd0,    1'b0}},
            // even pieces never reach an odd total
            '{10'd17,   10'd4,    10'd6,    10'd8,    1'b1, '{10'd0,    1'b0}},
            '{10'd10,   10'd3,    10'd3,    10'd3,    1'b1, '{10'd0,    1'b0}},
            '{10'd9,    10'd3,    10'd3,    10'd3,    1'b1, '{10'd3,    1'b1}},
            '{10'd682,  10'd0,    10'd0,    10'd2,    1'b1, '{10'd341,  1'b1}},
            '{10'd341,  10'd1,    10'd0,    10'd0,    1'b1, '{10'd341,  1'b1}},
            '{10'd1022, 10'd2,    10'd1023, 10'd0,    1'b1, '{10'd511,  1'b1}},
            '{10'd7,    10'd5,    10'd3,    10'd2,    1'b0, '{10'd0,    1'b0}},
            '{10'd11,   10'd2,    10'd3,    10'd5,    1'b0, '{10'd0,    1'b0}},
            '{10'd512,  10'd512,  10'd256,  10'd1,    1'b0, '{10'd0,    1'b0}},
            '{10'd341,  10'd341,  10'd682,  10'd85,   1'b0, '{10'd0,    1'b0}}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, no idling
        for (int r = 0; r < NUM_ROWS; r++)
            send_query(directed_rows[r].total, directed_rows[r].a, directed_rows[r].b,
                       directed_rows[r].c, directed_rows[r].typed, directed_rows[r].want);

        // random phases; each one starts with the query side held until drained
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
                default: begin send_gap_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    // long fill: full-range total and lengths, one short length
                    t = LEN_W'($urandom_range(0, 1023));
                    a = LEN_W'($urandom_range(1, 1023));
                    b = LEN_W'($urandom_range(0, 1023));
                    c = LEN_W'($urandom_range(1, 31));
                end
                else if (pick == 1)
                begin
                    // noise: lengths anywhere, mostly too long to fit
                    t = LEN_W'($urandom_range(0, 127));
                    a = LEN_W'($urandom_range(0, 1023));
                    b = LEN_W'($urandom_range(0, 1023));
                    c = LEN_W'($urandom_range(0, 1023));
                end
                else
                begin
                    // common case: short totals and short segments
                    t = LEN_W'($urandom_range(0, 96));
                    a = short_len();
                    b = short_len();
                    c = short_len();
                end
                send_query(t, a, b, c, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS max_segment_cut_count");
        else
            $display("FAIL max_segment_cut_count");
        $finish;
    end

endmodule
